>>> hw/rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg: shared constants for the ponderomotive position push
// Register map, configuration widths and reset values.
// ----------------------------------------------------------------------------
package ppp_pkg;

	localparam int CFG_BITS      = 47;
	localparam int APB_DATA_BITS = 64;
	localparam int APB_ADDR_BITS = 5;
	localparam int CHARGE_BITS   = 8;
	localparam int DIM_BITS      = 2;

	typedef enum logic [1:0] {
		REG_INV_MASS   = 2'd0,
		REG_QUARTER_DT = 2'd1,
		REG_DT         = 2'd2,
		REG_DIMS       = 2'd3
	} reg_idx_t;

	localparam logic [CFG_BITS-1:0] INV_MASS_RESET = 47'd16777216;
	localparam logic [DIM_BITS-1:0] DIMS_RESET     = 2'd3;

endpackage

>>> hw/rtl/ppp_dly.sv
// ----------------------------------------------------------------------------
// ppp_dly: fixed-length delay line
// Carries payload alongside the arithmetic units through a chain of DEPTH registers.
// ----------------------------------------------------------------------------
module ppp_dly #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	generate
		if (DEPTH == 0) begin : g_none
			assign q = d;
		end else begin : g_line
			logic [WIDTH-1:0] tap_q [DEPTH];
			always_ff @(posedge clk) begin
				tap_q[0] <= d;
				for (int i = 1; i < DEPTH; i++) begin
					tap_q[i] <= tap_q[i-1];
				end
			end
			assign q = tap_q[DEPTH-1];
		end
	endgenerate

endmodule

>>> hw/rtl/ppp_mul.sv
// ----------------------------------------------------------------------------
// ppp_mul: two-stage saturating fixed-point multiplier
// Sign-magnitude product from four half-width partial products, shifted
// right by SHIFT with truncation toward zero, saturated to the word range.
// ----------------------------------------------------------------------------
module ppp_mul #(
	parameter int WORD_BITS = 48,
	parameter int SHIFT     = 24
) (
	input  logic                        clk,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] y
);

	localparam int W  = WORD_BITS;
	localparam int HL = (W + 1) / 2;
	localparam int HH = W - HL;
	localparam int PW = 2 * W;

	logic [W-1:0] ma, mb;
	assign ma = a[W-1] ? (~a + 1'b1) : a;
	assign mb = b[W-1] ? (~b + 1'b1) : b;

	logic [2*HL-1:0]  p00_s1;
	logic [HL+HH-1:0] p01_s1, p10_s1;
	logic [2*HH-1:0]  p11_s1;
	logic             neg_s1;

	always_ff @(posedge clk) begin
		p00_s1 <= ma[HL-1:0] * mb[HL-1:0];
		p01_s1 <= ma[HL-1:0] * mb[W-1:HL];
		p10_s1 <= ma[W-1:HL] * mb[HL-1:0];
		p11_s1 <= ma[W-1:HL] * mb[W-1:HL];
		neg_s1 <= a[W-1] ^ b[W-1];
	end

	logic [PW-1:0] full, shv, lim, mag;
	logic [W-1:0]  mv;
	always_comb begin
		full = (PW'(p11_s1) << (2 * HL)) + (PW'(p01_s1) << HL) + (PW'(p10_s1) << HL)
			+ PW'(p00_s1);
		shv  = full >> SHIFT;
		lim  = neg_s1 ? (PW'(1) << (W - 1)) : ((PW'(1) << (W - 1)) - PW'(1));
		mag  = (shv > lim) ? lim : shv;
		mv   = mag[W-1:0];
	end

	logic [W-1:0] y_s2;
	always_ff @(posedge clk) begin
		y_s2 <= neg_s1 ? (~mv + 1'b1) : mv;
	end
	assign y = y_s2;

endmodule

>>> hw/rtl/ppp_div.sv
// ----------------------------------------------------------------------------
// ppp_div: pipelined saturating fixed-point divider
// Computes (a << FRACTION_BITS) / b truncated toward zero, one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module ppp_div #(
	parameter int WORD_BITS     = 48,
	parameter int FRACTION_BITS = 24
) (
	input  logic                        clk,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	output logic signed [WORD_BITS-1:0] y
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int NW = W + F;
	localparam int CW = NW + W;

	logic [W-1:0]  n, d;
	logic [NW-1:0] num;
	assign n   = a[W-1] ? (~a + 1'b1) : a;
	assign d   = b[W-1] ? (~b + 1'b1) : b;
	assign num = {n, {F{1'b0}}};

	logic [W-1:0] r_s   [W];
	logic [W-2:0] n_s   [W];
	logic [W-2:0] q_s   [W];
	logic [W-1:0] d_s   [W];
	logic         neg_s [W];
	logic         sat_s [W];
	logic         zro_s [W];

	// quotient would not fit in W-1 bits: clip at the limit
	always_ff @(posedge clk) begin
		r_s[0]   <= W'(num >> (W - 1));
		n_s[0]   <= num[W-2:0];
		q_s[0]   <= '0;
		d_s[0]   <= d;
		neg_s[0] <= a[W-1] ^ b[W-1];
		sat_s[0] <= CW'(num) >= (CW'(d) << (W - 1));
		zro_s[0] <= (n == '0);
	end

	genvar gi;
	generate
		for (gi = 1; gi < W; gi++) begin : g_step
			logic [W:0] rr, rd;
			logic       ge;
			assign rr = {r_s[gi-1], n_s[gi-1][W-2]};
			assign ge = rr >= {1'b0, d_s[gi-1]};
			assign rd = rr - {1'b0, d_s[gi-1]};
			always_ff @(posedge clk) begin
				r_s[gi]   <= ge ? rd[W-1:0] : rr[W-1:0];
				n_s[gi]   <= n_s[gi-1] << 1;
				q_s[gi]   <= {q_s[gi-1][W-3:0], ge};
				d_s[gi]   <= d_s[gi-1];
				neg_s[gi] <= neg_s[gi-1];
				sat_s[gi] <= sat_s[gi-1];
				zro_s[gi] <= zro_s[gi-1];
			end
		end
	endgenerate

	logic [W-1:0] lim, mv;
	always_comb begin
		lim = neg_s[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		mv  = sat_s[W-1] ? lim : {1'b0, q_s[W-1]};
	end

	logic [W-1:0] y_q;
	always_ff @(posedge clk) begin
		if (zro_s[W-1]) begin
			y_q <= '0;
		end else begin
			y_q <= neg_s[W-1] ? (~mv + 1'b1) : mv;
		end
	end
	assign y = y_q;

endmodule

>>> hw/rtl/ppp_sqrt.sv
// ----------------------------------------------------------------------------
// ppp_sqrt: pipelined fixed-point square root
// Floor of sqrt(x << FRACTION_BITS), one root bit per stage, zero for a
// non-positive radicand, limited to the largest word.
// ----------------------------------------------------------------------------
module ppp_sqrt #(
	parameter int WORD_BITS     = 48,
	parameter int FRACTION_BITS = 24
) (
	input  logic                        clk,
	input  logic signed [WORD_BITS-1:0] x,
	output logic signed [WORD_BITS-1:0] y
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int XW = W - 1 + F;
	localparam int RB = (XW + 1) / 2;
	localparam int CW = (RB > W) ? RB : W;

	logic [2*RB-1:0] x_s    [RB+1];
	logic [RB:0]     rem_s  [RB+1];
	logic [RB-1:0]   root_s [RB+1];

	// drop a negative or zero radicand to zero
	always_ff @(posedge clk) begin
		x_s[0]    <= (!x[W-1] && x != '0) ? (2*RB)'({x[W-2:0], {F{1'b0}}}) : '0;
		rem_s[0]  <= '0;
		root_s[0] <= '0;
	end

	genvar gi;
	generate
		for (gi = 1; gi <= RB; gi++) begin : g_step
			logic [RB+2:0] rem2, trial, diff;
			logic          ge;
			assign rem2  = {rem_s[gi-1], x_s[gi-1][2*RB-1:2*RB-2]};
			assign trial = (RB+3)'({root_s[gi-1], 2'b01});
			assign ge    = rem2 >= trial;
			assign diff  = rem2 - trial;
			always_ff @(posedge clk) begin
				x_s[gi]    <= x_s[gi-1] << 2;
				rem_s[gi]  <= ge ? diff[RB:0] : rem2[RB:0];
				root_s[gi] <= (RB)'({root_s[gi-1], ge});
			end
		end
	endgenerate

	localparam logic [CW-1:0] MAXW_C = CW'({1'b0, {(W-1){1'b1}}});

	logic [W-1:0] y_q;
	always_ff @(posedge clk) begin
		y_q <= (CW'(root_s[RB]) > MAXW_C) ? MAXW_C[W-1:0] : W'(root_s[RB]);
	end
	assign y = y_q;

endmodule

>>> hw/rtl/ponderomotive_position_push.sv
// ----------------------------------------------------------------------------
// ponderomotive_position_push: envelope-aware particle position advance
// Computes ponderomotive gamma and advances positions, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration goes through the APB port (64-bit data, register i at byte
//   address 8*i); write it only while the pipeline is empty.
//   A particle request is taken at each rising edge with start high and busy
//   low. busy is always low: one particle is accepted every cycle.
//   Each result appears on the pos_*_out and last_out ports for exactly one
//   cycle with done high, in request order. At the defaults the long
//   divider chains set the pipeline depth. Reset clears the valid chain
//   and loads the register reset values; items in flight are dropped.
//   The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module ponderomotive_position_push #(
	parameter int WORD_BITS     = 48,
	parameter int FRACTION_BITS = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ppp_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [ppp_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [ppp_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [ppp_pkg::CHARGE_BITS-1:0] particle_charge,
	input  logic signed [WORD_BITS-1:0]          mom_x,
	input  logic signed [WORD_BITS-1:0]          mom_y,
	input  logic signed [WORD_BITS-1:0]          mom_z,
	input  logic signed [WORD_BITS-1:0]          potential,
	input  logic signed [WORD_BITS-1:0]          grad_x,
	input  logic signed [WORD_BITS-1:0]          grad_y,
	input  logic signed [WORD_BITS-1:0]          grad_z,
	input  logic signed [WORD_BITS-1:0]          pos_x_in,
	input  logic signed [WORD_BITS-1:0]          pos_y_in,
	input  logic signed [WORD_BITS-1:0]          pos_z_in,
	input  logic                                 last_particle,
	output logic                                 done,
	output logic signed [WORD_BITS-1:0]          pos_x_out,
	output logic signed [WORD_BITS-1:0]          pos_y_out,
	output logic signed [WORD_BITS-1:0]          pos_z_out,
	output logic                                 last_out
);

	import ppp_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int LD  = W + 1;
	localparam int LS  = (W - 1 + F + 1) / 2 + 2;
	localparam int X   = (LD + 3 > LS) ? LD + 3 : LS;
	localparam int TG  = 10 + X;
	localparam int LAT = TG + LD + 1;
	localparam int CMW = (W > CFG_BITS) ? W : CFG_BITS;

	localparam logic [W-1:0] MAXW_U = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINW_U = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE_W  = (F < W - 1) ? (W'(1) << F) : MAXW_U;

	function automatic logic [W-1:0] addsat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? MINW_U : MAXW_U;
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] reg_val(input logic [CFG_BITS-1:0] r);
		if (CMW'(r) > CMW'(MAXW_U)) begin
			return MAXW_U;
		end
		return W'(r);
	endfunction

	// ---------------- configuration ----------------
	logic [CFG_BITS-1:0] inv_mass_q, qdt_q, dt_q;
	logic [DIM_BITS-1:0] dims_q;
	reg_idx_t            ridx;

	assign ridx   = reg_idx_t'(paddr[APB_ADDR_BITS-1:APB_ADDR_BITS-2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= INV_MASS_RESET;
			qdt_q      <= '0;
			dt_q       <= '0;
			dims_q     <= DIMS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (ridx)
				REG_INV_MASS:   inv_mass_q <= pwdata[CFG_BITS-1:0];
				REG_QUARTER_DT: qdt_q      <= pwdata[CFG_BITS-1:0];
				REG_DT:         dt_q       <= pwdata[CFG_BITS-1:0];
				REG_DIMS:       dims_q     <= pwdata[DIM_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_INV_MASS:   prdata = APB_DATA_BITS'(inv_mass_q);
			REG_QUARTER_DT: prdata = APB_DATA_BITS'(qdt_q);
			REG_DT:         prdata = APB_DATA_BITS'(dt_q);
			REG_DIMS:       prdata = APB_DATA_BITS'(dims_q);
		endcase
	end

	logic [W-1:0] inv_v, qdt_v, dt_v;
	assign inv_v = reg_val(inv_mass_q);
	assign qdt_v = reg_val(qdt_q);
	assign dt_v  = reg_val(dt_q);

	// ---------------- request and valid chain ----------------
	logic             acc;
	logic [LAT-1:0]   vld_q;
	assign busy = 1'b0;
	assign acc  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], acc};
		end
	end
	assign done = vld_q[LAT-1];

	// ---------------- gamma squared ----------------
	logic [W-1:0] q_w;
	assign q_w = {{(W-CHARGE_BITS){particle_charge[CHARGE_BITS-1]}}, particle_charge};

	logic [W-1:0] qq_s2, qm_s2, pxx_s2, pyy_s2, pzz_s2;
	logic [W-1:0] qqi_s4, cs_s4, phi_s4, phics_s6, c4_s6;

	ppp_mul #(.WORD_BITS(W), .SHIFT(0)) u_qq  (.clk, .a(q_w), .b(q_w), .y(qq_s2));
	ppp_mul #(.WORD_BITS(W), .SHIFT(0)) u_qm  (.clk, .a(q_w), .b(inv_v), .y(qm_s2));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_pxx (.clk, .a(mom_x), .b(mom_x), .y(pxx_s2));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_pyy (.clk, .a(mom_y), .b(mom_y), .y(pyy_s2));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_pzz (.clk, .a(mom_z), .b(mom_z), .y(pzz_s2));
	ppp_mul #(.WORD_BITS(W), .SHIFT(0)) u_qqi (.clk, .a(qq_s2), .b(inv_v), .y(qqi_s4));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_cs  (.clk, .a(qm_s2), .b(qm_s2), .y(cs_s4));
	ppp_dly #(.WIDTH(W), .DEPTH(4))     u_phid (.clk, .d(potential), .q(phi_s4));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_phcs (.clk, .a(phi_s4), .b(cs_s4), .y(phics_s6));
	ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_c4  (.clk, .a(qqi_s4), .b(qdt_v), .y(c4_s6));

	logic [W-1:0] s1_s3, pyy_s3, pzz_s3, s2_s4, pzz_s4, s3_s5, s3_s6, g0sq_s7, g0sq_s8;
	// accumulate in model order, saturating at each step
	always_ff @(posedge clk) begin
		s1_s3   <= addsat(ONE_W, pxx_s2);
		pyy_s3  <= pyy_s2;
		pzz_s3  <= pzz_s2;
		s2_s4   <= addsat(s1_s3, pyy_s3);
		pzz_s4  <= pzz_s3;
		s3_s5   <= addsat(s2_s4, pzz_s4);
		s3_s6   <= s3_s5;
		g0sq_s7 <= addsat(s3_s6, phics_s6);
		g0sq_s8 <= g0sq_s7;
	end

	// ---------------- gradient correction ----------------
	logic [3*W-1:0] gr_s6, pa, pb;
	ppp_dly #(.WIDTH(3*W), .DEPTH(6)) u_grd (.clk, .d({grad_z, grad_y, grad_x}), .q(gr_s6));
	ppp_dly #(.WIDTH(3*W), .DEPTH(8 + LD)) u_pa (.clk, .d({mom_z, mom_y, mom_x}), .q(pa));
	ppp_dly #(.WIDTH(3*W), .DEPTH(X - LD)) u_pb (.clk, .d(pa), .q(pb));

	logic [W-1:0] g0, g0_a;
	ppp_sqrt #(.WORD_BITS(W), .FRACTION_BITS(F)) u_sqrt (.clk, .x(g0sq_s7), .y(g0));
	ppp_dly #(.WIDTH(W), .DEPTH(X - LS)) u_g0d (.clk, .d(g0), .q(g0_a));

	logic [W-1:0] t_k [3], sk [3], sp [3], sp_a [3], u_k [3], dq [3];

	genvar gk;
	generate
		for (gk = 0; gk < 3; gk++) begin : g_axis
			ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_t (
				.clk, .a(c4_s6), .b(gr_s6[gk*W +: W]), .y(t_k[gk]));
			ppp_div #(.WORD_BITS(W), .FRACTION_BITS(F)) u_sk (
				.clk, .a(t_k[gk]), .b(g0sq_s8), .y(sk[gk]));
			ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_sp (
				.clk, .a(sk[gk]), .b(pa[gk*W +: W]), .y(sp[gk]));
			ppp_dly #(.WIDTH(W), .DEPTH(X - LD - 3)) u_spd (
				.clk, .d(sp[gk]), .q(sp_a[gk]));
			ppp_mul #(.WORD_BITS(W), .SHIFT(F)) u_u (
				.clk, .a(dt_v), .b(pb[gk*W +: W]), .y(u_k[gk]));
		end
	endgenerate

	logic [W-1:0] gx_sa1, spy_sa1, spz_sa1, gy_sa2, spz_sa2, g_sa3;
	always_ff @(posedge clk) begin
		gx_sa1  <= addsat(g0_a, sp_a[0]);
		spy_sa1 <= sp_a[1];
		spz_sa1 <= sp_a[2];
		gy_sa2  <= addsat(gx_sa1, spy_sa1);
		spz_sa2 <= spz_sa1;
		g_sa3   <= addsat(gy_sa2, spz_sa2);
	end

	// ---------------- position advance ----------------
	generate
		for (gk = 0; gk < 3; gk++) begin : g_adv
			ppp_div #(.WORD_BITS(W), .FRACTION_BITS(F)) u_dq (
				.clk, .a(u_k[gk]), .b(g_sa3), .y(dq[gk]));
		end
	endgenerate

	logic [3*W:0] posd;
	ppp_dly #(.WIDTH(3*W + 1), .DEPTH(TG + LD)) u_posd (
		.clk, .d({last_particle, pos_z_in, pos_y_in, pos_x_in}), .q(posd));

	logic [W-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic         last_q;
	// skip coordinates beyond the configured dimension count
	always_ff @(posedge clk) begin
		pos_x_q <= (dims_q >= 2'd1) ? addsat(posd[0 +: W], dq[0]) : posd[0 +: W];
		pos_y_q <= (dims_q >= 2'd2) ? addsat(posd[W +: W], dq[1]) : posd[W +: W];
		pos_z_q <= (dims_q == 2'd3) ? addsat(posd[2*W +: W], dq[2]) : posd[2*W +: W];
		last_q  <= posd[3*W];
	end

	assign pos_x_out = pos_x_q;
	assign pos_y_out = pos_y_q;
	assign pos_z_out = pos_z_q;
	assign last_out  = last_q;

`ifndef SYNTH
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result strobe without a matching request");
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request lost in the pipeline");
	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last_out == $past(last_particle, LAT)))
		else $error("batch end mark out of step with its result");
`endif

endmodule
